>>> hdl/mid_insert_sequence_store_unit_defines.svh
// Assertion macros shared by the sequence store RTL.
// Included by files that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef MID_INSERT_SEQUENCE_STORE_UNIT_DEFINES_SVH
`define MID_INSERT_SEQUENCE_STORE_UNIT_DEFINES_SVH

// Checked at every rising clock edge outside reset.
`define MISU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define MISU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hdl/misu_pkg.sv
// Package for the sequence store: sizes, op and status codes, beat types.
// Has no dependencies; every other RTL file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package misu_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 7;
  localparam int VAL_W   = 32;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_MID   = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_MID   = 3'd4,
    OP_REM_BACK  = 3'd5,
    OP_READ      = 3'd6,
    OP_NOP       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] element;
    status_e                 status;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } out_beat_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic emit;     // load the next read-out element into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;    // no elements held
    logic out_free; // output register can be loaded this cycle
    logic rd_last;  // read pointer is on the final element
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/misu_ctrl.sv
// Controller for the sequence store: takes input beats and sequences read-outs.
// Depends on misu_pkg; drives commands into misu_dpath and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module misu_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  misu_pkg::op_e    op_i,
  input  misu_pkg::stat_t  stat_i,
  output logic             in_stall_o,
  output misu_pkg::cmd_t   cmd_o
);

  misu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= misu_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      misu_pkg::S_IDLE: begin
        in_stall_o   = !stat_i.out_free;
        cmd_o.accept = in_valid_i && stat_i.out_free;
        if (cmd_o.accept && (op_i == misu_pkg::OP_READ) && !stat_i.empty) begin
          state_d = misu_pkg::S_READ;
        end
      end
      misu_pkg::S_READ: begin
        cmd_o.emit = stat_i.out_free;
        if (stat_i.out_free && stat_i.rd_last) begin
          state_d = misu_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = misu_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/misu_dpath.sv
// Datapath for the sequence store: shifting element cells, count, read pointer
// and output register. Depends on misu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "mid_insert_sequence_store_unit_defines.svh"

module misu_dpath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  misu_pkg::in_beat_t  in_data_i,
  input  misu_pkg::cmd_t      cmd_i,
  input  wire                 out_stall_i,
  output misu_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  output misu_pkg::out_beat_t out_data_o
);

  localparam int CNT_W = misu_pkg::CNT_W;
  localparam int IDX_W = misu_pkg::IDX_W;

  logic signed [misu_pkg::VAL_W-1:0] cells_q [misu_pkg::DEPTH];
  logic signed [misu_pkg::VAL_W-1:0] cells_d [misu_pkg::DEPTH];
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 out_valid_q, out_valid_d;
  misu_pkg::out_beat_t  out_data_q, out_data_d;

  logic                 full, empty;
  logic [CNT_W:0]       cnt_inc;
  logic [CNT_W-1:0]     mid_ins, mid_rem, pos;
  logic                 do_ins, do_rem;

  assign full    = (count_q == CNT_W'(misu_pkg::DEPTH));
  assign empty   = (count_q == '0);
  assign cnt_inc = {1'b0, count_q} + (CNT_W + 1)'(1);
  assign mid_ins = cnt_inc[CNT_W:1];
  assign mid_rem = mid_ins - CNT_W'(1);

  assign stat_o.empty    = empty;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign stat_o.rd_last  = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q);

  // Decode the accepted beat into an insert or remove and its position.
  always_comb begin
    do_ins = 1'b0;
    do_rem = 1'b0;
    pos    = '0;
    unique case (in_data_i.op)
      misu_pkg::OP_INS_FRONT: begin
        do_ins = !full;
        pos    = '0;
      end
      misu_pkg::OP_INS_MID: begin
        do_ins = !full;
        pos    = mid_ins;
      end
      misu_pkg::OP_INS_BACK: begin
        do_ins = !full;
        pos    = count_q;
      end
      misu_pkg::OP_REM_FRONT: begin
        do_rem = !empty;
        pos    = '0;
      end
      misu_pkg::OP_REM_MID: begin
        do_rem = !empty;
        pos    = mid_rem;
      end
      misu_pkg::OP_REM_BACK: begin
        do_rem = !empty;
        pos    = count_q - CNT_W'(1);
      end
      default: begin
        do_ins = 1'b0;
        do_rem = 1'b0;
      end
    endcase
    do_ins = do_ins && cmd_i.accept;
    do_rem = do_rem && cmd_i.accept;
  end

  // Every cell looks only at its neighbors, so all cells shift together in the same cycle.
  always_comb begin
    for (int i = 0; i < misu_pkg::DEPTH; i++) begin
      cells_d[i] = cells_q[i];
      if (do_ins) begin
        if (CNT_W'(i) == pos) begin
          cells_d[i] = in_data_i.value;
        end else if ((i > 0) && (CNT_W'(i) > pos)) begin
          cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_rem) begin
        if ((i < misu_pkg::DEPTH - 1) && (CNT_W'(i) >= pos)) begin
          cells_d[i] = cells_q[(i < misu_pkg::DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.accept) begin
      rd_idx_d           = '0;
      out_data_d.element = '0;
      out_data_d.count   = misu_pkg::COUNT_W'(count_d);
      out_data_d.last    = 1'b1;
      out_data_d.status  = misu_pkg::ST_OK;
      if ((in_data_i.op == misu_pkg::OP_INS_FRONT || in_data_i.op == misu_pkg::OP_INS_MID ||
           in_data_i.op == misu_pkg::OP_INS_BACK) && full) begin
        out_data_d.status = misu_pkg::ST_FULL;
      end else if ((in_data_i.op == misu_pkg::OP_REM_FRONT ||
                    in_data_i.op == misu_pkg::OP_REM_MID ||
                    in_data_i.op == misu_pkg::OP_REM_BACK ||
                    in_data_i.op == misu_pkg::OP_READ) && empty) begin
        out_data_d.status = misu_pkg::ST_EMPTY;
      end
      // A read-out of a non-empty store emits nothing now; the elements follow.
      out_valid_d = !((in_data_i.op == misu_pkg::OP_READ) && !empty);
    end else if (cmd_i.emit) begin
      out_data_d.element = cells_q[rd_idx_q];
      out_data_d.status  = misu_pkg::ST_OK;
      out_data_d.count   = misu_pkg::COUNT_W'(count_q);
      out_data_d.last    = stat_o.rd_last;
      out_valid_d        = 1'b1;
      rd_idx_d           = rd_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q    <= cells_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `MISU_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(misu_pkg::DEPTH), "count above depth")
  `MISU_ASSERT(a_count_only_on_accept, !cmd_i.accept |=> $stable(count_q), "count moved idle")
  `MISU_ASSERT(a_mutation_result, (cmd_i.accept && in_data_i.op != misu_pkg::OP_READ) |=> out_valid_q, "no result for request")
  `MISU_ASSERT(a_emit_slot_free, cmd_i.emit |-> stat_o.out_free, "element emitted over pending result")
  `MISU_ASSERT(a_no_accept_and_emit, !(cmd_i.accept && cmd_i.emit), "accept during read-out")

endmodule

`default_nettype wire

>>> hdl/mid_insert_sequence_store_unit.sv
// An insert or remove gives its single result beat, registered, in the cycle after acceptance.
// Inserts and removes run at one beat per cycle unless the output stalls; a read-out of N
// elements holds off input after acceptance; one element per cycle unless output stalls.
// Every cell shifts in the same cycle, so a middle insert or remove is as fast as one at an end.
// Reset clears the count, read pointer, controller state and output valid; cell contents
// are left as they are, since a cell is only read after it has been written.
`timescale 1ns / 1ps
`default_nettype none

module mid_insert_sequence_store_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  misu_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output misu_pkg::out_beat_t out_data_o
);

  // The controller decides when an input beat is taken and walks the read
  // pointer through a read-out. It sees only input valid, the op code and datapath status.
  misu_pkg::cmd_t  cmd;
  misu_pkg::stat_t stat;

  misu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_data_i.op),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // The datapath holds the elements in a row of cells that can all shift by one
  // place at once, the element count, the read pointer and the output register.
  // The output register is loaded whenever it is empty or being drained, so a new
  // beat is taken while the previous result is still being handed off.
  misu_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
